// File: rtl/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies; clock clk and reset rst_n are taken from the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AST_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mahs_pkg.sv
// types, constants and lookup tables for the mpeg audio header decoder
// no dependencies
`timescale 1ns / 1ps

package mahs_pkg;

    localparam logic [31:0] SYNC_MASK     = 32'hFFE0_0000;
    localparam logic [1:0]  VER_RESERVED  = 2'b01;
    localparam logic [1:0]  VER_MPEG1     = 2'b11;
    localparam logic [1:0]  LAY_RESERVED  = 2'b00;
    localparam logic [3:0]  BIDX_FREE     = 4'h0;
    localparam logic [3:0]  BIDX_BAD      = 4'hF;
    localparam logic [1:0]  SIDX_RESERVED = 2'b11;
    localparam logic [1:0]  LAYER_I       = 2'd1;
    localparam logic [1:0]  LAYER_II      = 2'd2;
    localparam logic [1:0]  MODE_JOINT    = 2'b01;
    localparam logic [1:0]  MODE_MONO     = 2'b11;
    localparam logic [17:0] SCALE_L1      = 18'd12000;
    localparam logic [17:0] SCALE_L23     = 18'd144000;
    localparam logic [5:0]  SIDE_M1_STEREO = 6'd32;
    localparam logic [5:0]  SIDE_M1_MONO   = 6'd17;
    localparam logic [5:0]  SIDE_LSF_STEREO = 6'd17;
    localparam logic [5:0]  SIDE_LSF_MONO   = 6'd9;
    localparam logic [2:0]  CNT_MAX       = 3'd7;
    localparam logic [2:0]  CNT_CHECK     = 3'd4;
    localparam logic [3:0]  QUO_MSB       = 4'd11;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_FIN,
        BK_HOLD
    } bk_state_t;

    typedef struct packed {
        logic [31:0] word;
        logic        skipped;
    } hdr_beat_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic is_header(input logic [31:0] w);
        logic ok;
        begin
            ok = ((w & SYNC_MASK) == SYNC_MASK);
            if (w[20:19] == VER_RESERVED)
                ok = 1'b0;
            if (w[18:17] == LAY_RESERVED)
                ok = 1'b0;
            if (w[15:12] == BIDX_BAD || w[15:12] == BIDX_FREE)
                ok = 1'b0;
            if (w[11:10] == SIDX_RESERVED)
                ok = 1'b0;
            return ok;
        end
    endfunction

    // lidx: 0 layer I, 1 layer II, 2 layer III
    function automatic logic [8:0] kbps_lookup(input logic lsf, input logic [1:0] lidx,
                                               input logic [3:0] bidx);
        logic [8:0] v;
        begin
            v = 9'd0;
            unique case ({lsf, lidx})
                3'b000: begin
                    case (bidx)
                        4'd1: v = 9'd32;   4'd2: v = 9'd64;   4'd3: v = 9'd96;
                        4'd4: v = 9'd128;  4'd5: v = 9'd160;  4'd6: v = 9'd192;
                        4'd7: v = 9'd224;  4'd8: v = 9'd256;  4'd9: v = 9'd288;
                        4'd10: v = 9'd320; 4'd11: v = 9'd352; 4'd12: v = 9'd384;
                        4'd13: v = 9'd416; 4'd14: v = 9'd448;
                        default: v = 9'd0;
                    endcase
                end
                3'b001: begin
                    case (bidx)
                        4'd1: v = 9'd32;   4'd2: v = 9'd48;   4'd3: v = 9'd56;
                        4'd4: v = 9'd64;   4'd5: v = 9'd80;   4'd6: v = 9'd96;
                        4'd7: v = 9'd112;  4'd8: v = 9'd128;  4'd9: v = 9'd160;
                        4'd10: v = 9'd192; 4'd11: v = 9'd224; 4'd12: v = 9'd256;
                        4'd13: v = 9'd320; 4'd14: v = 9'd384;
                        default: v = 9'd0;
                    endcase
                end
                3'b010: begin
                    case (bidx)
                        4'd1: v = 9'd32;   4'd2: v = 9'd40;   4'd3: v = 9'd48;
                        4'd4: v = 9'd56;   4'd5: v = 9'd64;   4'd6: v = 9'd80;
                        4'd7: v = 9'd96;   4'd8: v = 9'd112;  4'd9: v = 9'd128;
                        4'd10: v = 9'd160; 4'd11: v = 9'd192; 4'd12: v = 9'd224;
                        4'd13: v = 9'd256; 4'd14: v = 9'd320;
                        default: v = 9'd0;
                    endcase
                end
                3'b100: begin
                    case (bidx)
                        4'd1: v = 9'd32;   4'd2: v = 9'd48;   4'd3: v = 9'd56;
                        4'd4: v = 9'd64;   4'd5: v = 9'd80;   4'd6: v = 9'd96;
                        4'd7: v = 9'd112;  4'd8: v = 9'd128;  4'd9: v = 9'd144;
                        4'd10: v = 9'd160; 4'd11: v = 9'd176; 4'd12: v = 9'd192;
                        4'd13: v = 9'd224; 4'd14: v = 9'd256;
                        default: v = 9'd0;
                    endcase
                end
                3'b101, 3'b110: begin
                    case (bidx)
                        4'd1: v = 9'd8;    4'd2: v = 9'd16;   4'd3: v = 9'd24;
                        4'd4: v = 9'd32;   4'd5: v = 9'd40;   4'd6: v = 9'd48;
                        4'd7: v = 9'd56;   4'd8: v = 9'd64;   4'd9: v = 9'd80;
                        4'd10: v = 9'd96;  4'd11: v = 9'd112; 4'd12: v = 9'd128;
                        4'd13: v = 9'd144; 4'd14: v = 9'd160;
                        default: v = 9'd0;
                    endcase
                end
                default: v = 9'd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic [15:0] rate_lookup(input logic [1:0] ver, input logic [1:0] sidx);
        logic [15:0] v;
        begin
            unique case ({ver, sidx})
                4'b0000: v = 16'd11025;
                4'b0001: v = 16'd12000;
                4'b0010: v = 16'd8000;
                4'b1000: v = 16'd22050;
                4'b1001: v = 16'd24000;
                4'b1010: v = 16'd16000;
                4'b1100: v = 16'd44100;
                4'b1101: v = 16'd48000;
                4'b1110: v = 16'd32000;
                default: v = 16'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: rtl/mpeg_audio_header_sync_decode.sv
// mpeg audio frame header sync and decode, top level
// depends on mahs_pkg, mahs_front, mahs_fifo, mahs_back and assert_macros.svh
//
// input channel: one stream byte per beat on stream_byte with in_valid/in_ready.
// output channel: one decoded frame header per beat with out_valid/out_ready.
// the front shifts bytes into a 32-bit window at one byte per cycle while
// in_ready is high and, once four bytes have arrived since reset or the last
// match, checks for a header. matched headers go into a two-entry queue;
// in_ready drops only while it is full. the back decodes one header at a time:
// queue pop, scaling multiply, a 12-step restoring divide for the frame length
// (one quotient bit a cycle) and a final step that sets the result valid; it
// takes the next header only after the receiver has accepted the result.
// a stalled receiver holds the output register; the queue then fills and the
// byte stream is back-pressured.
// reset clears the window, byte count, queue and output valid; no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mpeg_audio_header_sync_decode
    import mahs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  stream_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  version_id,
    output logic [1:0]  layer,
    output logic        crc_present,
    output logic [8:0]  bitrate_kbps,
    output logic [15:0] sample_rate_hz,
    output logic        padding,
    output logic [1:0]  channel_mode,
    output logic [1:0]  stereo_tools,
    output logic [11:0] frame_bytes,
    output logic [5:0]  side_info_bytes,
    output logic [11:0] main_data_bytes,
    output logic        bytes_skipped
);

    q_stat_t   q_stat;
    logic      push;
    hdr_beat_t push_beat;
    logic      pop;
    hdr_beat_t pop_beat;
    bk_state_t bk_state;

    mahs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .stream_byte (stream_byte),
        .q_stat      (q_stat),
        .push        (push),
        .push_beat   (push_beat)
    );

    mahs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_beat (push_beat),
        .pop       (pop),
        .pop_beat  (pop_beat),
        .q_stat    (q_stat)
    );

    mahs_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_stat          (q_stat),
        .pop_beat        (pop_beat),
        .pop             (pop),
        .bk_state        (bk_state),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .version_id      (version_id),
        .layer           (layer),
        .crc_present     (crc_present),
        .bitrate_kbps    (bitrate_kbps),
        .sample_rate_hz  (sample_rate_hz),
        .padding         (padding),
        .channel_mode    (channel_mode),
        .stereo_tools    (stereo_tools),
        .frame_bytes     (frame_bytes),
        .side_info_bytes (side_info_bytes),
        .main_data_bytes (main_data_bytes),
        .bytes_skipped   (bytes_skipped)
    );

    `AST_SAME(a_push_not_full, push, !q_stat.full, "header pushed into a full queue")
    `AST_SAME(a_pop_not_empty, pop, !q_stat.empty, "header popped from an empty queue")
    `AST_SAME(a_valid_in_hold, out_valid, bk_state == BK_HOLD, "result valid outside hold")
    `AST_NEXT(a_fin_to_valid, bk_state == BK_FIN, out_valid, "finished decode not shown")

endmodule

// File: rtl/mahs_front.sv
// byte window, fill count and header match; pushes matched headers to the queue
// depends on mahs_pkg
`timescale 1ns / 1ps

module mahs_front
    import mahs_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      stream_byte,
    input  q_stat_t         q_stat,
    output logic            push,
    output hdr_beat_t       push_beat
);

    logic [31:0] win_reg;
    logic [31:0] win_next;
    logic [2:0]  cnt_reg;
    logic [2:0]  cnt_next;
    logic [31:0] win_shift;
    logic [2:0]  cnt_inc;
    logic        accept;
    logic        hit;

    assign in_ready  = !q_stat.full;
    assign accept    = in_valid && in_ready;
    assign win_shift = {win_reg[23:0], stream_byte};
    assign cnt_inc   = (cnt_reg == CNT_MAX) ? CNT_MAX : cnt_reg + 3'd1;
    assign hit       = (cnt_inc >= CNT_CHECK) && is_header(win_shift);

    assign push              = accept && hit;
    assign push_beat.word    = win_shift;
    assign push_beat.skipped = (cnt_inc > CNT_CHECK);

    always_comb
    begin
        win_next = win_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (hit)
            begin
                win_next = 32'd0;
                cnt_next = 3'd0;
            end
            else
            begin
                win_next = win_shift;
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= 32'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            win_reg <= win_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: rtl/mahs_fifo.sv
// two-entry queue of matched header beats between front and back
// depends on mahs_pkg
`timescale 1ns / 1ps

module mahs_fifo
    import mahs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  hdr_beat_t push_beat,
    input  logic      pop,
    output hdr_beat_t pop_beat,
    output q_stat_t   q_stat
);

    hdr_beat_t   mem_reg [0:1];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;
    logic        do_push;
    logic        do_pop;

    assign q_stat.full  = (fill_reg == 2'd2);
    assign q_stat.empty = (fill_reg == 2'd0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_beat     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 2'd1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_beat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// File: rtl/mahs_back.sv
// header field decode, bitrate scaling multiply, bit-serial frame length divide
// and the output register; depends on mahs_pkg
`timescale 1ns / 1ps

module mahs_back
    import mahs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_stat_t     q_stat,
    input  hdr_beat_t   pop_beat,
    output logic        pop,
    output bk_state_t   bk_state,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  version_id,
    output logic [1:0]  layer,
    output logic        crc_present,
    output logic [8:0]  bitrate_kbps,
    output logic [15:0] sample_rate_hz,
    output logic        padding,
    output logic [1:0]  channel_mode,
    output logic [1:0]  stereo_tools,
    output logic [11:0] frame_bytes,
    output logic [5:0]  side_info_bytes,
    output logic [11:0] main_data_bytes,
    output logic        bytes_skipped
);

    bk_state_t   state_reg;
    bk_state_t   state_next;
    logic [31:0] hdr_reg;
    logic [31:0] hdr_next;
    logic        skip_reg;
    logic        skip_next;
    logic [25:0] rem_reg;
    logic [25:0] rem_next;
    logic [16:0] div_reg;
    logic [16:0] div_next;
    logic [11:0] quo_reg;
    logic [11:0] quo_next;
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;
    logic        vld_reg;
    logic        vld_next;

    logic [1:0]  ver_reg, ver_next;
    logic [1:0]  lay_reg, lay_next;
    logic        crc_reg, crc_next;
    logic [8:0]  br_reg, br_next;
    logic [15:0] sr_reg, sr_next;
    logic        pad_reg, pad_next;
    logic [1:0]  mode_reg, mode_next;
    logic [1:0]  tools_reg, tools_next;
    logic [11:0] frame_reg, frame_next;
    logic [5:0]  side_reg, side_next;
    logic [11:0] main_reg, main_next;
    logic        skipo_reg, skipo_next;

    logic [1:0]  d_ver;
    logic [1:0]  d_lay;
    logic        d_lsf;
    logic [8:0]  d_br;
    logic [15:0] d_sr;
    logic [17:0] d_scale;
    logic [26:0] d_prod;
    logic [16:0] d_div;
    logic [27:0] rem_ext;
    logic [27:0] div_sh;
    logic [27:0] rem_sub;
    logic [11:0] q_pad;
    logic [11:0] f_len;
    logic [5:0]  s_len;
    logic [11:0] crc_len;

    assign d_ver   = hdr_reg[20:19];
    assign d_lay   = 2'd0 - hdr_reg[18:17];
    assign d_lsf   = (d_ver != VER_MPEG1);
    assign d_br    = kbps_lookup(d_lsf, ~hdr_reg[18:17], hdr_reg[15:12]);
    assign d_sr    = rate_lookup(d_ver, hdr_reg[11:10]);
    assign d_scale = (d_lay == LAYER_I) ? SCALE_L1 : SCALE_L23;
    assign d_prod  = 27'(d_br) * 27'(d_scale);
    assign d_div   = (d_lay != LAYER_I && d_lay != LAYER_II && d_lsf) ?
                     {d_sr, 1'b0} : {1'b0, d_sr};

    assign rem_ext = {2'b00, rem_reg};
    assign div_sh  = {11'd0, div_reg} << cnt_reg;
    assign rem_sub = rem_ext - div_sh;

    assign q_pad   = quo_reg + {11'd0, hdr_reg[9]};
    assign f_len   = (lay_reg == LAYER_I) ? {q_pad[9:0], 2'b00} : q_pad;
    assign crc_len = hdr_reg[16] ? 12'd0 : 12'd2;

    always_comb
    begin
        if (lay_reg == LAYER_I || lay_reg == LAYER_II)
            s_len = 6'd0;
        else if (ver_reg == VER_MPEG1)
            s_len = (hdr_reg[7:6] == MODE_MONO) ? SIDE_M1_MONO : SIDE_M1_STEREO;
        else
            s_len = (hdr_reg[7:6] == MODE_MONO) ? SIDE_LSF_MONO : SIDE_LSF_STEREO;
    end

    always_comb
    begin
        state_next = state_reg;
        hdr_next   = hdr_reg;
        skip_next  = skip_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        vld_next   = vld_reg;
        ver_next   = ver_reg;
        lay_next   = lay_reg;
        crc_next   = crc_reg;
        br_next    = br_reg;
        sr_next    = sr_reg;
        pad_next   = pad_reg;
        mode_next  = mode_reg;
        tools_next = tools_reg;
        frame_next = frame_reg;
        side_next  = side_reg;
        main_next  = main_reg;
        skipo_next = skipo_reg;
        pop        = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    hdr_next   = pop_beat.word;
                    skip_next  = pop_beat.skipped;
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                rem_next   = d_prod[25:0];
                div_next   = d_div;
                quo_next   = 12'd0;
                cnt_next   = QUO_MSB;
                ver_next   = d_ver;
                lay_next   = d_lay;
                br_next    = d_br;
                sr_next    = d_sr;
                state_next = BK_DIV;
            end
            BK_DIV:
            begin
                if (rem_ext >= div_sh)
                begin
                    rem_next          = rem_sub[25:0];
                    quo_next[cnt_reg] = 1'b1;
                end
                if (cnt_reg == 4'd0)
                    state_next = BK_FIN;
                else
                    cnt_next = cnt_reg - 4'd1;
            end
            BK_FIN:
            begin
                crc_next   = !hdr_reg[16];
                pad_next   = hdr_reg[9];
                mode_next  = hdr_reg[7:6];
                tools_next = (hdr_reg[7:6] == MODE_JOINT) ? hdr_reg[5:4] : 2'd0;
                frame_next = f_len;
                side_next  = s_len;
                main_next  = f_len - 12'd4 - {6'd0, s_len} - crc_len;
                skipo_next = skip_reg;
                vld_next   = 1'b1;
                state_next = BK_HOLD;
            end
            BK_HOLD:
            begin
                if (out_ready)
                begin
                    vld_next   = 1'b0;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg   <= hdr_next;
        skip_reg  <= skip_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        ver_reg   <= ver_next;
        lay_reg   <= lay_next;
        crc_reg   <= crc_next;
        br_reg    <= br_next;
        sr_reg    <= sr_next;
        pad_reg   <= pad_next;
        mode_reg  <= mode_next;
        tools_reg <= tools_next;
        frame_reg <= frame_next;
        side_reg  <= side_next;
        main_reg  <= main_next;
        skipo_reg <= skipo_next;
    end

    assign bk_state        = state_reg;
    assign out_valid       = vld_reg;
    assign version_id      = ver_reg;
    assign layer           = lay_reg;
    assign crc_present     = crc_reg;
    assign bitrate_kbps    = br_reg;
    assign sample_rate_hz  = sr_reg;
    assign padding         = pad_reg;
    assign channel_mode    = mode_reg;
    assign stereo_tools    = tools_reg;
    assign frame_bytes     = frame_reg;
    assign side_info_bytes = side_reg;
    assign main_data_bytes = main_reg;
    assign bytes_skipped   = skipo_reg;

endmodule

// File: tb/tb_top.sv
// self-checking bench for mpeg_audio_header_sync_decode: byte stream in, decoded headers out
// needs mahs_pkg and the rtl below it; headers are predicted here from the byte window
`timescale 1ns / 1ps

module tb_top;
    import mahs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_BYTES = 330;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef struct packed {
        logic [1:0]  version_id;
        logic [1:0]  layer;
        logic        crc_present;
        logic [8:0]  bitrate_kbps;
        logic [15:0] sample_rate_hz;
        logic        padding;
        logic [1:0]  channel_mode;
        logic [1:0]  stereo_tools;
        logic [11:0] frame_bytes;
        logic [5:0]  side_info_bytes;
        logic [11:0] main_data_bytes;
        logic        bytes_skipped;
    } frame_info_t;

    typedef struct packed {
        logic [1:0]  n_lead;
        logic [23:0] lead;
        logic [31:0] word;
        logic        typed;
        frame_info_t want;
    } hdr_row_t;

    localparam frame_info_t NONE = '0;

    localparam int unsigned KBPS_TAB [2][3][16] = '{
        '{
            '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
            '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
            '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0}
        },
        '{
            '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
            '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
            '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
        }
    };

    localparam int unsigned RATE_TAB [4][3] = '{
        '{11025, 12000, 8000},
        '{0, 0, 0},
        '{22050, 24000, 16000},
        '{44100, 48000, 32000}
    };

    // lead bytes go out first, oldest in the top byte used
    localparam hdr_row_t DIR_ROWS [13] = '{
        '{2'd0, 24'h0, 32'hFFFB_9064, 1'b1,
          '{2'd3, 2'd3, 1'b0, 9'd128, 16'd44100, 1'b0, 2'd1, 2'd2,
            12'd417, 6'd32, 12'd381, 1'b0}},
        '{2'd0, 24'h0, 32'hFFFE_E6C0, 1'b1,
          '{2'd3, 2'd1, 1'b1, 9'd448, 16'd48000, 1'b1, 2'd3, 2'd0,
            12'd452, 6'd0, 12'd446, 1'b0}},
        '{2'd2, 24'h00_0012, 32'hFFE5_EA80, 1'b1,
          '{2'd0, 2'd2, 1'b0, 9'd160, 16'd8000, 1'b1, 2'd2, 2'd0,
            12'd2881, 6'd0, 12'd2877, 1'b1}},
        '{2'd0, 24'h0, 32'hFFF2_14C0, 1'b0, NONE},
        '{2'd0, 24'h0, 32'hFFE7_5230, 1'b0, NONE},
        '{2'd0, 24'h0, 32'hFFFC_1870, 1'b0, NONE},
        '{2'd0, 24'h0, 32'hFFFB_90FF, 1'b0, NONE},
        '{2'd3, 24'hFB_9064, 32'hFFFB_9064, 1'b0, NONE},
        '{2'd0, 24'h0, 32'hFFEB_9064, 1'b0, NONE},
        '{2'd0, 24'h0, 32'hFFF9_9064, 1'b0, NONE},
        '{2'd0, 24'h0, 32'hFFFB_F064, 1'b0, NONE},
        '{2'd0, 24'h0, 32'hFFFB_0064, 1'b0, NONE},
        '{2'd1, 24'h00_0000, 32'hFFFB_9C64, 1'b0, NONE}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  stream_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  version_id;
    logic [1:0]  layer;
    logic        crc_present;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic        padding;
    logic [1:0]  channel_mode;
    logic [1:0]  stereo_tools;
    logic [11:0] frame_bytes;
    logic [5:0]  side_info_bytes;
    logic [11:0] main_data_bytes;
    logic        bytes_skipped;

    logic [31:0] win_bytes = '0;
    logic [2:0]  win_count = '0;
    frame_info_t pending_hdrs [$];
    int unsigned mismatch_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned cycle_count = 0;
    bit          steady = 1'b0;
    bit          tx_burst = 1'b0;
    bit          hold_go = 1'b0;

    mpeg_audio_header_sync_decode dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .stream_byte     (stream_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .version_id      (version_id),
        .layer           (layer),
        .crc_present     (crc_present),
        .bitrate_kbps    (bitrate_kbps),
        .sample_rate_hz  (sample_rate_hz),
        .padding         (padding),
        .channel_mode    (channel_mode),
        .stereo_tools    (stereo_tools),
        .frame_bytes     (frame_bytes),
        .side_info_bytes (side_info_bytes),
        .main_data_bytes (main_data_bytes),
        .bytes_skipped   (bytes_skipped)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic logic sync_hit(input logic [31:0] w);
        return ((w & SYNC_MASK) == SYNC_MASK) && (w[20:19] != VER_RESERVED)
            && (w[18:17] != LAY_RESERVED) && (w[15:12] != BIDX_FREE)
            && (w[15:12] != BIDX_BAD) && (w[11:10] != SIDX_RESERVED);
    endfunction

    // shifts one byte into the window; returns 1 with the decoded header on a match
    function automatic logic decode_next_byte(input logic [7:0] b, output frame_info_t r);
        logic [31:0] w;
        logic [1:0]  lay;
        logic        lsf;
        int unsigned br;
        int unsigned sr;
        int unsigned frame;
        int unsigned side;
        int unsigned mlen;
        r = '0;
        win_bytes = {win_bytes[23:0], b};
        if (win_count != 3'd7)
            win_count++;
        w = win_bytes;
        if (win_count < 3'd4 || !sync_hit(w))
            return 1'b0;
        r.bytes_skipped = (win_count > 3'd4);
        win_bytes = '0;
        win_count = '0;

        lay = 2'(3'd4 - {1'b0, w[18:17]});
        lsf = (w[20:19] != VER_MPEG1);
        br = KBPS_TAB[lsf][lay - 2'd1][w[15:12]];
        sr = RATE_TAB[w[20:19]][w[11:10]];
        side = 0;
        if (lay == LAYER_I)
            frame = ((br * 12000) / sr + w[9]) * 4;
        else if (lay == LAYER_II)
            frame = (br * 144000) / sr + w[9];
        else
        begin
            frame = (br * 144000) / (sr << lsf) + w[9];
            if (!lsf)
                side = (w[7:6] == MODE_MONO) ? 17 : 32;
            else
                side = (w[7:6] == MODE_MONO) ? 9 : 17;
        end
        mlen = frame - 4 - side - (w[16] ? 0 : 2);

        r.version_id      = w[20:19];
        r.layer           = lay;
        r.crc_present     = ~w[16];
        r.bitrate_kbps    = 9'(br);
        r.sample_rate_hz  = 16'(sr);
        r.padding         = w[9];
        r.channel_mode    = w[7:6];
        r.stereo_tools    = (w[7:6] == MODE_JOINT) ? w[5:4] : 2'd0;
        r.frame_bytes     = 12'(frame);
        r.side_info_bytes = 6'(side);
        r.main_data_bytes = 12'(mlen);
        return 1'b1;
    endfunction

    function automatic logic [31:0] rand_header();
        logic [1:0] ver;
        case ($urandom_range(0, 2))
            0: ver = 2'b00;
            1: ver = 2'b10;
            default: ver = VER_MPEG1;
        endcase
        return {11'h7FF, ver, 2'($urandom_range(1, 3)), 1'($urandom),
                4'($urandom_range(1, 14)), 2'($urandom_range(0, 2)), 2'($urandom),
                8'($urandom)};
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic typed, input frame_info_t want);
        frame_info_t info;
        while (!steady && !tx_burst && $urandom_range(0, 99) < 12)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        stream_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        if (decode_next_byte(b, info))
            pending_hdrs.push_back(typed ? want : info);
    endtask

    // sends the top nbytes bytes of w; a typed expectation applies to the last one
    task automatic put_word(input logic [31:0] w, input int nbytes, input logic typed,
                            input frame_info_t want);
        for (int i = 3; i > 3 - nbytes; i--)
            put_byte(w[8*i +: 8], typed && (i == 4 - nbytes), want);
    endtask

    task automatic drain_pending();
        in_valid <= 1'b0;
        while (pending_hdrs.size() != 0)
            @(posedge clk);
    endtask

    task automatic chk(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic take_result();
        frame_info_t got;
        frame_info_t want;
        got = {version_id, layer, crc_present, bitrate_kbps, sample_rate_hz, padding,
               channel_mode, stereo_tools, frame_bytes, side_info_bytes, main_data_bytes,
               bytes_skipped};
        if (pending_hdrs.size() == 0)
        begin
            $display("%0t: header beat expected none actual frame_bytes %0d",
                     $time, got.frame_bytes);
            mismatch_count++;
            return;
        end
        want = pending_hdrs.pop_front();
        chk("version_id", want.version_id, got.version_id);
        chk("layer", want.layer, got.layer);
        chk("crc_present", want.crc_present, got.crc_present);
        chk("bitrate_kbps", want.bitrate_kbps, got.bitrate_kbps);
        chk("sample_rate_hz", want.sample_rate_hz, got.sample_rate_hz);
        chk("padding", want.padding, got.padding);
        chk("channel_mode", want.channel_mode, got.channel_mode);
        chk("stereo_tools", want.stereo_tools, got.stereo_tools);
        chk("frame_bytes", want.frame_bytes, got.frame_bytes);
        chk("side_info_bytes", want.side_info_bytes, got.side_info_bytes);
        chk("main_data_bytes", want.main_data_bytes, got.main_data_bytes);
        chk("bytes_skipped", want.bytes_skipped, got.bytes_skipped);
    endtask

    // receiver: random back-pressure plus one long hold
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                take_result();
            if (hold_go)
            begin
                hold_go = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= steady || ($urandom_range(0, 99) >= 12);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int unsigned rand_start;
        int unsigned pick;
        int          nb;
        logic [31:0] w;
        logic        all_ff;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_ROWS[r])
        begin
            for (int i = int'(DIR_ROWS[r].n_lead) - 1; i >= 0; i--)
                put_byte(DIR_ROWS[r].lead[8*i +: 8], 1'b0, NONE);
            put_word(DIR_ROWS[r].word, 4, DIR_ROWS[r].typed, DIR_ROWS[r].want);
        end
        drain_pending();

        // long receiver hold while headers keep coming, so the queue backs up
        tx_burst = 1'b1;
        hold_go = 1'b1;
        repeat (16) put_word(rand_header(), 4, 1'b0, NONE);
        tx_burst = 1'b0;
        drain_pending();

        rand_start = bytes_sent;
        while (bytes_sent - rand_start < RANDOM_BYTES)
        begin
            steady = (bytes_sent - rand_start >= 150) && (bytes_sent - rand_start < 260);
            pick = $urandom_range(0, 99);
            nb = 4;
            if (pick < 70)
            begin
                repeat ($urandom_range(0, 3)) put_byte(8'($urandom), 1'b0, NONE);
                put_word(rand_header(), 4, 1'b0, NONE);
            end
            else if (pick < 85)
            begin
                w = rand_header();
                case ($urandom_range(0, 6))
                    0: w[20:19] = VER_RESERVED;
                    1: w[18:17] = LAY_RESERVED;
                    2: w[15:12] = BIDX_BAD;
                    3: w[15:12] = BIDX_FREE;
                    4: w[11:10] = SIDX_RESERVED;
                    5: w[21 + $urandom_range(0, 10)] = 1'b0;
                    default: nb = $urandom_range(1, 3);
                endcase
                put_word(w, nb, 1'b0, NONE);
            end
            else
            begin
                all_ff = ($urandom_range(0, 3) == 0);
                repeat ($urandom_range(1, 10))
                    put_byte(all_ff ? 8'hFF : 8'($urandom), 1'b0, NONE);
            end
        end
        steady = 1'b0;
        drain_pending();
        repeat (40) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
